[hdl/two_party_frame_confirm_buffer_defines.svh]
// ----------------------------------------------------------------------------
// two_party_frame_confirm_buffer_defines
// Assertion macros used by the frame confirm buffer back module (tpfc_back).
// ----------------------------------------------------------------------------
`ifndef TWO_PARTY_FRAME_CONFIRM_BUFFER_DEFINES_SVH
`define TWO_PARTY_FRAME_CONFIRM_BUFFER_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define TPFC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define TPFC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/tpfc_pkg.sv]
// ----------------------------------------------------------------------------
// tpfc_pkg
// Sizes, codes and types of the two-party frame confirm buffer.
// ----------------------------------------------------------------------------
package tpfc_pkg;

    // Pending window and history ring (both powers of two).
    localparam int WINDOW      = 32;
    localparam int HIST_DEPTH  = 4096;
    localparam int MAX_CATCHUP = 40;
    localparam int MAX_RESULTS = 40;
    localparam int CU_LIMIT    = (MAX_CATCHUP < MAX_RESULTS) ? MAX_CATCHUP : MAX_RESULTS;

    localparam int SLOT_AW = $clog2(WINDOW);
    localparam int HIST_AW = $clog2(HIST_DEPTH);
    localparam int HCNT_W  = $clog2(HIST_DEPTH + 1);
    localparam int CNT_W   = $clog2(MAX_RESULTS + 1);

    // Field widths
    localparam int FRAME_W = 31;
    localparam int WORD_W  = 32;
    localparam int CONF_W  = 32;
    localparam int KIND_W  = 2;

    // Highest frame number, as a confirmed-frame value
    localparam logic signed [CONF_W-1:0] CONF_MAX = 32'sh7fff_ffff;

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request function codes
    localparam logic OP_CONTRIB = 1'b0;
    localparam logic OP_CATCHUP = 1'b1;

    // Party codes
    localparam logic PARTY_FIRST  = 1'b0;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_CONFIRM = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RECORD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

    // Classified command, front to back
    typedef struct packed {
        logic               op;
        logic [1:0]         got_mask;
        logic [SLOT_AW-1:0] slot_idx;
        logic [FRAME_W-1:0] frame;
        logic [WORD_W-1:0]  word;
    } cmd_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic not_empty;
        logic not_full;
    } q_status_t;

endpackage

[hdl/tpfc_req_if.sv]
// ----------------------------------------------------------------------------
// tpfc_req_if
// Request channel: contribution or catch-up beats with valid/ready.
// ----------------------------------------------------------------------------
interface tpfc_req_if;
    import tpfc_pkg::*;

    logic               valid;
    logic               ready;
    logic               func;
    logic               party;
    logic [FRAME_W-1:0] frame_number;
    logic [WORD_W-1:0]  input_bits;

    modport source (output valid, func, party, frame_number, input_bits, input ready);
    modport sink   (input valid, func, party, frame_number, input_bits, output ready);
endinterface

[hdl/tpfc_rsp_if.sv]
// ----------------------------------------------------------------------------
// tpfc_rsp_if
// Response channel: confirm and catch-up result beats with valid/ready.
// ----------------------------------------------------------------------------
interface tpfc_rsp_if;
    import tpfc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [FRAME_W-1:0]       out_frame;
    logic [WORD_W-1:0]        first_bits;
    logic [WORD_W-1:0]        second_bits;
    logic signed [CONF_W-1:0] latest_confirmed;
    logic                     last;

    modport source (output valid, kind, out_frame, first_bits, second_bits,
                    latest_confirmed, last, input ready);
    modport sink   (input valid, kind, out_frame, first_bits, second_bits,
                    latest_confirmed, last, output ready);
endinterface

[hdl/tpfc_front.sv]
// ----------------------------------------------------------------------------
// tpfc_front
// Accepts request beats and classifies them into queue commands.
// ----------------------------------------------------------------------------
module tpfc_front (
    tpfc_req_if.sink            request,
    input  tpfc_pkg::q_status_t q_stat,
    output logic                push,
    output tpfc_pkg::cmd_t      cmd
);
    import tpfc_pkg::*;

    // Accept whenever the queue has room
    assign request.ready = q_stat.not_full;
    assign push          = request.valid && q_stat.not_full;

    // Classify: op code, party got bit, slot index in the pending ring
    always_comb
    begin
        cmd.op       = (request.func == OP_CATCHUP) ? OP_CATCHUP : OP_CONTRIB;
        cmd.got_mask = 2'b00;
        if (request.func == OP_CONTRIB)
        begin
            cmd.got_mask = (request.party == PARTY_FIRST) ? 2'b01 : 2'b10;
        end
        cmd.slot_idx = request.frame_number[SLOT_AW-1:0];
        cmd.frame    = request.frame_number;
        cmd.word     = request.input_bits;
    end
endmodule

[hdl/tpfc_queue.sv]
// ----------------------------------------------------------------------------
// tpfc_queue
// Short command FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module tpfc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tpfc_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output tpfc_pkg::cmd_t      pop_cmd,
    output tpfc_pkg::q_status_t stat
);
    import tpfc_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign stat.not_empty = (count_reg != '0);
    assign stat.not_full  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign do_push        = push && stat.not_full;
    assign do_pop         = pop && stat.not_empty;
    assign pop_cmd        = entry_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule

[hdl/tpfc_back.sv]
// ----------------------------------------------------------------------------
// tpfc_back
// Executes commands: slot fill, in-order drain, history replay.
// ----------------------------------------------------------------------------
`include "two_party_frame_confirm_buffer_defines.svh"

module tpfc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tpfc_pkg::cmd_t      q_cmd,
    input  tpfc_pkg::q_status_t q_stat,
    output logic                pop,
    tpfc_rsp_if.source          response
);
    import tpfc_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DRAIN  = 2'd1;
    localparam logic [1:0] S_CU_CHK = 2'd2;
    localparam logic [1:0] S_CU_RD  = 2'd3;

    // Control state
    logic [1:0]               state_reg, state_next;
    logic signed [CONF_W-1:0] cf_reg, cf_next;
    logic [HCNT_W-1:0]        hc_reg, hc_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [FRAME_W-1:0]       cu_frame_reg, cu_frame_next;
    logic [1:0]               got_reg [WINDOW];

    // Pending slot words and history ring
    logic [WORD_W-1:0]        slot_a_mem [WINDOW];
    logic [WORD_W-1:0]        slot_b_mem [WINDOW];
    logic [2*WORD_W-1:0]      hist_mem [HIST_DEPTH];
    logic [2*WORD_W-1:0]      hist_rdata_reg;

    // Output register
    logic                     out_valid_reg;
    logic [KIND_W-1:0]        kind_reg;
    logic [FRAME_W-1:0]       frame_reg;
    logic [WORD_W-1:0]        a_reg;
    logic [WORD_W-1:0]        b_reg;
    logic signed [CONF_W-1:0] latest_reg;
    logic                     last_reg;

    // Step controls
    logic                     out_free;
    logic                     emit;
    logic [KIND_W-1:0]        e_kind;
    logic [FRAME_W-1:0]       e_frame;
    logic [WORD_W-1:0]        e_a;
    logic [WORD_W-1:0]        e_b;
    logic signed [CONF_W-1:0] e_latest;
    logic                     e_last;
    logic                     slot_we;
    logic                     got_clr;
    logic                     hist_we;
    logic                     hist_re;
    logic [HIST_AW-1:0]       hist_raddr;

    // Frame arithmetic (33-bit signed to cover minus one and the top frame)
    logic signed [CONF_W:0]   cf_ext;
    logic signed [CONF_W:0]   fr_ext;
    logic signed [CONF_W:0]   cu_ext;
    logic signed [CONF_W:0]   diff;
    logic signed [CONF_W:0]   oldest;
    logic                     in_window;
    logic signed [CONF_W-1:0] next_frame;
    logic [SLOT_AW-1:0]       nidx;
    logic [SLOT_AW-1:0]       n2idx;
    logic                     can_drain;
    logic                     more_drain;
    logic [CNT_W-1:0]         n_inc;

    assign out_free   = !out_valid_reg || response.ready;
    assign cf_ext     = {cf_reg[CONF_W-1], cf_reg};
    assign fr_ext     = $signed({2'b00, q_cmd.frame});
    assign cu_ext     = $signed({2'b00, cu_frame_reg});
    assign diff       = fr_ext - cf_ext;
    assign in_window  = (diff > $signed((CONF_W+1)'(0)))
                     && (diff <= $signed((CONF_W+1)'(WINDOW)));
    assign oldest     = cf_ext - $signed((CONF_W+1)'(hc_reg)) + $signed((CONF_W+1)'(1));
    assign next_frame = cf_reg + CONF_W'(1);
    assign nidx       = next_frame[SLOT_AW-1:0];
    assign n2idx      = nidx + SLOT_AW'(1);
    assign n_inc      = n_reg + CNT_W'(1);
    assign can_drain  = (cf_reg != CONF_MAX) && (got_reg[nidx] == 2'b11);
    assign more_drain = (n_inc < CNT_W'(MAX_RESULTS)) && (next_frame != CONF_MAX)
                     && (got_reg[n2idx] == 2'b11);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        cf_next       = cf_reg;
        hc_next       = hc_reg;
        n_next        = n_reg;
        cu_frame_next = cu_frame_reg;
        pop           = 1'b0;
        slot_we       = 1'b0;
        got_clr       = 1'b0;
        hist_we       = 1'b0;
        hist_re       = 1'b0;
        hist_raddr    = cu_frame_reg[HIST_AW-1:0];
        emit          = 1'b0;
        e_kind        = KIND_EMPTY;
        e_frame       = '0;
        e_a           = '0;
        e_b           = '0;
        e_latest      = cf_reg;
        e_last        = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (q_stat.not_empty)
                begin
                    pop    = 1'b1;
                    n_next = '0;
                    if (q_cmd.op == OP_CONTRIB)
                    begin
                        slot_we    = in_window;
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        cu_frame_next = (fr_ext > oldest) ? q_cmd.frame : oldest[FRAME_W-1:0];
                        state_next    = S_CU_CHK;
                    end
                end
            end
            S_DRAIN:
            begin
                if (!can_drain)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    emit     = 1'b1;
                    e_kind   = KIND_CONFIRM;
                    e_frame  = next_frame[FRAME_W-1:0];
                    e_a      = slot_a_mem[nidx];
                    e_b      = slot_b_mem[nidx];
                    e_latest = next_frame;
                    e_last   = !more_drain;
                    got_clr  = 1'b1;
                    hist_we  = 1'b1;
                    cf_next  = next_frame;
                    n_next   = n_inc;
                    if (hc_reg != HCNT_W'(HIST_DEPTH))
                    begin
                        hc_next = hc_reg + HCNT_W'(1);
                    end
                    if (!more_drain)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_CU_CHK:
            begin
                if ((hc_reg == '0) || (cu_ext > cf_ext))
                begin
                    // No record at or after the start frame: one empty marker
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    hist_re    = 1'b1;
                    state_next = S_CU_RD;
                end
            end
            S_CU_RD:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    e_kind   = KIND_RECORD;
                    e_frame  = cu_frame_reg;
                    e_a      = hist_rdata_reg[WORD_W-1:0];
                    e_b      = hist_rdata_reg[2*WORD_W-1:WORD_W];
                    e_last   = (n_inc == CNT_W'(CU_LIMIT)) || (cu_ext == cf_ext);
                    n_next   = n_inc;
                    if (e_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cu_frame_next = cu_frame_reg + FRAME_W'(1);
                        hist_re       = 1'b1;
                        hist_raddr    = cu_frame_next[HIST_AW-1:0];
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers and got bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cf_reg        <= '1;
            hc_reg        <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW; i++)
            begin
                got_reg[i] <= 2'b00;
            end
        end
        else
        begin
            state_reg <= state_next;
            cf_reg    <= cf_next;
            hc_reg    <= hc_next;
            n_reg     <= n_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (got_clr)
            begin
                got_reg[nidx] <= 2'b00;
            end
            if (slot_we)
            begin
                got_reg[q_cmd.slot_idx] <= got_reg[q_cmd.slot_idx] | q_cmd.got_mask;
            end
        end
    end

    // Payload registers and slot words
    always_ff @(posedge clk)
    begin
        cu_frame_reg <= cu_frame_next;
        if (emit)
        begin
            kind_reg   <= e_kind;
            frame_reg  <= e_frame;
            a_reg      <= e_a;
            b_reg      <= e_b;
            latest_reg <= e_latest;
            last_reg   <= e_last;
        end
        if (slot_we && q_cmd.got_mask[0])
        begin
            slot_a_mem[q_cmd.slot_idx] <= q_cmd.word;
        end
        if (slot_we && q_cmd.got_mask[1])
        begin
            slot_b_mem[q_cmd.slot_idx] <= q_cmd.word;
        end
    end

    // History ring: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[next_frame[HIST_AW-1:0]] <= {slot_b_mem[nidx], slot_a_mem[nidx]};
        end
        if (hist_re)
        begin
            hist_rdata_reg <= hist_mem[hist_raddr];
        end
    end

    assign response.valid            = out_valid_reg;
    assign response.kind             = kind_reg;
    assign response.out_frame        = frame_reg;
    assign response.first_bits       = a_reg;
    assign response.second_bits      = b_reg;
    assign response.latest_confirmed = latest_reg;
    assign response.last             = last_reg;

    // Checks
    `TPFC_ASSERT_IMP(a_confirm_latest, out_valid_reg && (kind_reg == KIND_CONFIRM), latest_reg == $signed(CONF_W'(frame_reg)), "confirm beat frame differs from latest confirmed")
    `TPFC_ASSERT_IMP(a_empty_last, out_valid_reg && (kind_reg == KIND_EMPTY), last_reg, "empty catch-up beat without last mark")
    `TPFC_ASSERT_IMP(a_hist_bound, 1'b1, hc_reg <= HCNT_W'(HIST_DEPTH), "history count beyond ring depth")
    `TPFC_ASSERT_IMP(a_drain_count, state_reg == S_DRAIN, n_reg < CNT_W'(MAX_RESULTS), "drain ran past result limit")
    `TPFC_ASSERT_NXT(a_cf_monotonic, 1'b1, cf_reg >= $past(cf_reg), "confirmed frame went backward")
endmodule

[hdl/two_party_frame_confirm_buffer.sv]
// Path: a contribution passes the command queue, is written to its slot in S_IDLE,
// and its confirms leave the output register from S_DRAIN; a catch-up is checked in
// S_CU_CHK, which emits an empty marker or starts a registered history read, and its
// records leave from S_CU_RD. Within a drain or replay, one result per cycle while the
// response side is ready; fed by a 2-entry command queue that takes requests meanwhile.
// Reset: rst_n async, active low; clears got bits, counters and queue, no clearing pass.
// ----------------------------------------------------------------------------
// two_party_frame_confirm_buffer
// Lockstep merge buffer: pending slot ring, in-order confirm, history replay.
// ----------------------------------------------------------------------------
module two_party_frame_confirm_buffer (
    input  logic       clk,
    input  logic       rst_n,
    tpfc_req_if.sink   request,
    tpfc_rsp_if.source response
);
    import tpfc_pkg::*;

    cmd_t      push_cmd;
    cmd_t      pop_cmd;
    logic      push;
    logic      pop;
    q_status_t q_stat;

    // Front: accept and classify
    tpfc_front u_front (
        .request (request),
        .q_stat  (q_stat),
        .push    (push),
        .cmd     (push_cmd)
    );

    // Command queue
    tpfc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .stat     (q_stat)
    );

    // Back: fill, drain, replay
    tpfc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_cmd    (pop_cmd),
        .q_stat   (q_stat),
        .pop      (pop),
        .response (response)
    );
endmodule

[bench/two_party_frame_confirm_buffer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_party_frame_confirm_buffer_tb
// Self-checking bench for the two-party frame confirm buffer. Request beats
// come from a directed table and then from random, mostly well-formed
// contribution streams with catch-ups mixed in. A bench-side merge model
// predicts confirm and replay beats, some directed rows give theirs in the
// table; each response beat is matched field by field to the oldest prediction.
// ----------------------------------------------------------------------------
module two_party_frame_confirm_buffer_tb;
    import tpfc_pkg::*;

    localparam int DIR_ROWS        = 19;
    localparam int RANDOM_ITEMS    = 410;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int TAIL_CYCLES     = 32;
    localparam int MAX_REPORTS     = 10;
    localparam int AWAIT_DEPTH     = 256;
    localparam logic [FRAME_W-1:0] FRAME_TOP = '1;

    typedef struct packed {
        logic               func;
        logic               party;
        logic [FRAME_W-1:0] frame;
        logic [WORD_W-1:0]  bits;
    } req_beat_t;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [FRAME_W-1:0]       frame;
        logic [WORD_W-1:0]        first_w;
        logic [WORD_W-1:0]        second_w;
        logic signed [CONF_W-1:0] latest;
        logic                     last;
    } rsp_beat_t;

    // How a directed row is checked
    typedef enum logic [1:0] {
        BY_MODEL,
        NO_RESULT,
        ONE_RESULT
    } row_check_t;

    typedef struct packed {
        req_beat_t  req;
        row_check_t chk;
        rsp_beat_t  rsp;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    tpfc_req_if request_ch ();
    tpfc_rsp_if response_ch ();

    two_party_frame_confirm_buffer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    always #2 clk = ~clk;

    // Merge model state
    longint          conf_frame;
    logic [WORD_W-1:0] slot_a [WINDOW];
    logic [WORD_W-1:0] slot_b [WINDOW];
    logic [1:0]      slot_got [WINDOW];
    logic [63:0]     hist_ring [HIST_DEPTH];
    int              hist_fill;

    // Beats of the latest model step
    rsp_beat_t step_beats [MAX_RESULTS];
    int        step_cnt;

    // Predicted beats still to be seen, as a ring
    rsp_beat_t awaited_beats [AWAIT_DEPTH];
    int        await_wr;
    int        await_rd;

    int fail_cnt;
    int sent_items;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    // Directed table: extremes, window edges, overwrite, stale, empty replay
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{'{OP_CATCHUP, 1'b0, 31'd0, 32'h0}, ONE_RESULT,
          '{KIND_EMPTY, 31'd0, 32'h0, 32'h0, -32'sd1, 1'b1}},
        '{'{OP_CONTRIB, 1'b0, FRAME_TOP, 32'hffff_ffff}, NO_RESULT, '0},
        '{'{OP_CONTRIB, 1'b0, 31'd32, 32'h1234_5678}, NO_RESULT, '0},
        '{'{OP_CONTRIB, 1'b1, 31'd31, 32'hffff_ffff}, NO_RESULT, '0},
        '{'{OP_CONTRIB, 1'b0, 31'd31, 32'h0}, NO_RESULT, '0},
        '{'{OP_CONTRIB, 1'b0, 31'd0, 32'hffff_ffff}, NO_RESULT, '0},
        '{'{OP_CONTRIB, 1'b0, 31'd0, 32'ha5a5_5a5a}, NO_RESULT, '0},
        '{'{OP_CONTRIB, 1'b1, 31'd0, 32'h0}, ONE_RESULT,
          '{KIND_CONFIRM, 31'd0, 32'ha5a5_5a5a, 32'h0, 32'sd0, 1'b1}},
        '{'{OP_CONTRIB, 1'b1, 31'd0, 32'hffff_0000}, NO_RESULT, '0},
        '{'{OP_CATCHUP, 1'b1, FRAME_TOP, 32'hffff_ffff}, ONE_RESULT,
          '{KIND_EMPTY, 31'd0, 32'h0, 32'h0, 32'sd0, 1'b1}},
        '{'{OP_CATCHUP, 1'b0, 31'd0, 32'h0}, ONE_RESULT,
          '{KIND_RECORD, 31'd0, 32'ha5a5_5a5a, 32'h0, 32'sd0, 1'b1}},
        '{'{OP_CONTRIB, 1'b1, 31'd2, 32'h0000_ffff}, BY_MODEL, '0},
        '{'{OP_CONTRIB, 1'b0, 31'd2, 32'hffff_0000}, BY_MODEL, '0},
        '{'{OP_CONTRIB, 1'b0, 31'd1, 32'h5a5a_a5a5}, BY_MODEL, '0},
        '{'{OP_CONTRIB, 1'b1, 31'd1, 32'h8000_0001}, BY_MODEL, '0},
        '{'{OP_CATCHUP, 1'b1, 31'd1, 32'hffff_ffff}, BY_MODEL, '0},
        '{'{OP_CATCHUP, 1'b0, 31'd3, 32'h0}, ONE_RESULT,
          '{KIND_EMPTY, 31'd0, 32'h0, 32'h0, 32'sd2, 1'b1}},
        '{'{OP_CONTRIB, 1'b0, 31'h4000_0000, 32'h0f0f_0f0f}, NO_RESULT, '0},
        '{'{OP_CONTRIB, 1'b1, 31'd33, 32'hffff_ffff}, NO_RESULT, '0}
    };

    // Merge one request into the model; leaves its beats in step_beats.
    // Returns 1 when the request is not simply dropped.
    function automatic bit merge_step(input req_beat_t b);
        longint    fr;
        longint    nxt;
        longint    oldest;
        longint    f;
        int        idx;
        int        n;
        bit        taken;
        bit        stop;
        rsp_beat_t r;
        logic [63:0] w;

        fr    = longint'(b.frame);
        n     = 0;
        taken = 1'b1;
        stop  = 1'b0;
        if (b.func == OP_CONTRIB) begin
            taken = (fr > conf_frame) && (fr - conf_frame <= WINDOW);
            if (taken) begin
                idx = int'(fr % WINDOW);
                if (b.party == PARTY_FIRST)
                    slot_a[idx] = b.bits;
                else
                    slot_b[idx] = b.bits;
                slot_got[idx][b.party] = 1'b1;
            end
            // in-order drain while the next frame has both words
            while (!stop && n < MAX_RESULTS && conf_frame < longint'(CONF_MAX)) begin
                nxt = conf_frame + 1;
                idx = int'(nxt % WINDOW);
                if (slot_got[idx] != 2'b11) begin
                    stop = 1'b1;
                end
                else begin
                    hist_ring[int'(nxt % HIST_DEPTH)] = {slot_b[idx], slot_a[idx]};
                    if (hist_fill < HIST_DEPTH)
                        hist_fill++;
                    slot_got[idx] = 2'b00;
                    conf_frame    = nxt;
                    r = '{KIND_CONFIRM, FRAME_W'(nxt), slot_a[idx], slot_b[idx],
                          CONF_W'(conf_frame), 1'b0};
                    step_beats[n] = r;
                    n++;
                end
            end
        end
        else begin
            oldest = conf_frame - hist_fill + 1;
            f      = (fr > oldest) ? fr : oldest;
            if (hist_fill > 0) begin
                while (n < CU_LIMIT && f <= conf_frame) begin
                    w = hist_ring[int'(f % HIST_DEPTH)];
                    r = '{KIND_RECORD, FRAME_W'(f), w[31:0], w[63:32],
                          CONF_W'(conf_frame), 1'b0};
                    step_beats[n] = r;
                    n++;
                    f++;
                end
            end
            if (n == 0) begin
                r = '{KIND_EMPTY, '0, '0, '0, CONF_W'(conf_frame), 1'b0};
                step_beats[0] = r;
                n = 1;
            end
        end
        if (n > 0)
            step_beats[n-1].last = 1'b1;
        step_cnt = n;
        return taken;
    endfunction

    // Append one predicted beat to the ring
    function automatic void await_put(input rsp_beat_t r);
        awaited_beats[await_wr % AWAIT_DEPTH] = r;
        await_wr++;
    endfunction

    task automatic log_mismatch(input string why, input rsp_beat_t want,
                                input rsp_beat_t seen);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("%0t mismatch (%s): exp kind=%0d frame=%0d a=%h b=%h latest=%0d last=%0b",
                     $realtime, why, want.kind, want.frame, want.first_w, want.second_w,
                     want.latest, want.last,
                     "\n            got kind=%0d frame=%0d a=%h b=%h latest=%0d last=%0b",
                     seen.kind, seen.frame, seen.first_w, seen.second_w,
                     seen.latest, seen.last);
    endtask

    // Drive one request beat, wait for its handshake, then predict.
    task automatic issue(input req_beat_t b, input row_check_t chk, input rsp_beat_t typed);
        int gap;

        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_ch.valid        <= 1'b1;
        request_ch.func         <= b.func;
        request_ch.party        <= b.party;
        request_ch.frame_number <= b.frame;
        request_ch.input_bits   <= b.bits;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);

        void'(merge_step(b));
        sent_items++;
        case (chk)
            NO_RESULT:  ;
            ONE_RESULT: await_put(typed);
            default:    for (int i = 0; i < step_cnt; i++) await_put(step_beats[i]);
        endcase
    endtask

    // Fill the whole pending window, next frame last, so one beat drains it all
    task automatic fill_window_burst();
        longint    base;
        req_beat_t b;
        logic      p;

        base = conf_frame;
        for (int k = WINDOW; k >= 1; k--) begin
            p = 1'($urandom_range(0, 1));
            for (int j = 0; j < 2; j++) begin
                b.func  = OP_CONTRIB;
                b.party = (j == 0) ? p : ~p;
                b.frame = FRAME_W'(base + k);
                b.bits  = $urandom;
                issue(b, BY_MODEL, '0);
            end
        end
    endtask

    // Response side: random stall, check accepted beats, watchdog
    always @(posedge clk) begin
        rsp_beat_t seen;
        rsp_beat_t want;
        bit        moved;

        moved = 1'b0;
        if (rst_n) begin
            if (request_ch.valid && request_ch.ready)
                moved = 1'b1;
            if (response_ch.valid && response_ch.ready) begin
                moved = 1'b1;
                seen  = '{response_ch.kind, response_ch.out_frame, response_ch.first_bits,
                          response_ch.second_bits, response_ch.latest_confirmed,
                          response_ch.last};
                if (await_wr == await_rd) begin
                    log_mismatch("no beat awaited", '0, seen);
                end
                else begin
                    want = awaited_beats[await_rd % AWAIT_DEPTH];
                    await_rd++;
                    if (seen.kind != want.kind || seen.frame != want.frame ||
                        seen.first_w != want.first_w || seen.second_w != want.second_w ||
                        seen.latest != want.latest || seen.last != want.last)
                        log_mismatch("field", want, seen);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("watchdog: no handshake for %0d cycles, %0d beats awaited",
                         WATCHDOG_CYCLES, await_wr - await_rd);
                $display("CHECKS FAILED");
                $finish;
            end
        end
        response_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        req_beat_t b;
        int        sel;
        int        rnd_start;
        longint    oldest;
        longint    start;

        conf_frame     = -1;
        hist_fill      = 0;
        step_cnt       = 0;
        await_wr       = 0;
        await_rd       = 0;
        fail_cnt       = 0;
        sent_items     = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 10;
        recv_stall_pct = 51;
        foreach (slot_got[i]) slot_got[i] = 2'b00;

        rst_n                   <= 1'b0;
        request_ch.valid        <= 1'b0;
        request_ch.func         <= OP_CONTRIB;
        request_ch.party        <= 1'b0;
        request_ch.frame_number <= '0;
        request_ch.input_bits   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (directed_rows[i])
            issue(directed_rows[i].req, directed_rows[i].chk, directed_rows[i].rsp);

        // Random part: mostly in-window contributions, some noise and catch-ups
        rnd_start = sent_items;
        while (sent_items - rnd_start < RANDOM_ITEMS) begin
            if (sent_items - rnd_start >= 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            else if (sent_items - rnd_start >= RANDOM_ITEMS / 3) begin
                send_idle_pct  = 51;
                recv_stall_pct = 10;
            end
            sel     = $urandom_range(0, 999);
            b.func  = OP_CONTRIB;
            b.party = 1'($urandom_range(0, 1));
            b.bits  = $urandom;
            if (sel < 4) begin
                fill_window_burst();
            end
            else begin
                if (sel < 560) begin
                    b.frame = FRAME_W'(conf_frame + 1 + $urandom_range(0, 3));
                end
                else if (sel < 720) begin
                    b.frame = FRAME_W'(conf_frame + 1 + $urandom_range(0, WINDOW - 1));
                end
                else if (sel < 770) begin
                    // right at and just past the window edge
                    b.frame = FRAME_W'(conf_frame + WINDOW + $urandom_range(0, 1));
                end
                else if (sel < 820) begin
                    b.frame = (conf_frame >= 0) ?
                              FRAME_W'($urandom_range(0, int'(conf_frame))) : '0;
                end
                else if (sel < 850) begin
                    b.frame = FRAME_W'($urandom);
                end
                else begin
                    b.func = OP_CATCHUP;
                    oldest = conf_frame - hist_fill + 1;
                    case ($urandom_range(0, 3))
                        0:       start = oldest - 4 + $urandom_range(0, 12);
                        1:       start = conf_frame - $urandom_range(0, 6);
                        2:       start = conf_frame + 1 + $urandom_range(0, 100);
                        default: start = longint'($urandom) & 64'h7fff_ffff;
                    endcase
                    b.frame = (start < 0) ? '0 : FRAME_W'(start);
                end
                issue(b, BY_MODEL, '0);
            end
        end

        request_ch.valid <= 1'b0;
        while (await_wr != await_rd)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
